// ===== hdl/assert_macros.svh =====
// assertion macros shared by the queue and back pipeline modules
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define RCOM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RCOM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/rcom_pkg.sv =====
// types and constants of the rgba crossfade and over mixer
// no dependencies
package rcom_pkg;

    localparam int COLOR_W    = 16;
    localparam int ALPHA_W    = 16;
    localparam int FRAC       = 15;
    localparam int MAG_W      = 31;
    localparam int NUM_W      = 32;
    localparam int DIV_STEPS  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'h8000;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_MIX_A  = 2'd1;
    localparam logic [1:0] CFG_MIX_B  = 2'd2;

    localparam logic MODE_CROSS = 1'b0;
    localparam logic MODE_OVER  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [ALPHA_W-1:0] mix_a;
        logic [ALPHA_W-1:0] mix_b;
    } t_cfg;

    typedef struct packed {
        logic [2:0]                neg;
        logic [2:0][MAG_W-1:0]     mag;
        logic [ALPHA_W-1:0]        div;
        logic [ALPHA_W-1:0]        alpha;
    } t_job;

    function automatic logic [ALPHA_W-1:0] sat_one(input logic [ALPHA_W-1:0] v);
        return (v > ALPHA_ONE) ? ALPHA_ONE : v;
    endfunction

    function automatic logic [ALPHA_W-1:0] amul(input logic [ALPHA_W-1:0] x,
                                                input logic [ALPHA_W-1:0] y);
        logic [2*ALPHA_W-1:0] p;
        p = x * y;
        return p[FRAC+ALPHA_W-1:FRAC];
    endfunction

endpackage

// ===== hdl/rcom_front.sv =====
// front pipeline: clamps, alpha weights, classification, numerators
// depends on rcom_pkg
module rcom_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rcom_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [127:0]           i_data,
    input  logic [1:0]             i_user,
    input  logic                   i_full,
    output logic                   o_push,
    output rcom_pkg::t_job         o_job
);

    logic [4:0] r_v;
    logic       adv;

    // stage 1
    logic                    r1_over, r1_ma_zero, r1_mb_zero, r1_ap, r1_bp;
    logic [rcom_pkg::ALPHA_W-1:0] r1_p, r1_wb;
    logic [2:0][15:0]        r1_ca, r1_cb;
    // stage 2
    logic                    r2_ma_zero, r2_mb_zero, r2_ap, r2_bp;
    logic [rcom_pkg::ALPHA_W-1:0] r2_p, r2_wa, r2_wb;
    logic [2:0][15:0]        r2_ca, r2_cb;
    // stage 3
    logic [rcom_pkg::ALPHA_W-1:0] r3_ka, r3_kb, r3_div, r3_alpha;
    logic [2:0][15:0]        r3_ca, r3_cb;
    // stage 4
    logic [2:0][rcom_pkg::NUM_W-1:0] r4_pa, r4_pb;
    logic [rcom_pkg::ALPHA_W-1:0] r4_div, r4_alpha;
    // stage 5
    rcom_pkg::t_job          r5_job;

    logic [rcom_pkg::ALPHA_W-1:0] a_al, b_al, mb, ma;
    logic                    ap_in, bp_in;
    logic [rcom_pkg::ALPHA_W-1:0] n_ka, n_kb, n_div, n_alpha, sum;
    logic [2:0][rcom_pkg::NUM_W-1:0] n_pa, n_pb;
    rcom_pkg::t_job          n_job;

    assign adv     = !(r_v[4] && i_full);
    assign o_ready = adv;
    assign o_push  = r_v[4] && !i_full;
    assign o_job   = r5_job;

    always_comb begin
        logic over;
        over  = (i_cfg.mode == rcom_pkg::MODE_OVER);
        a_al  = rcom_pkg::sat_one(i_data[63:48]);
        b_al  = rcom_pkg::sat_one(i_data[127:112]);
        mb    = rcom_pkg::sat_one(i_cfg.mix_b);
        ma    = over ? rcom_pkg::sat_one(i_cfg.mix_a) : rcom_pkg::ALPHA_ONE - mb;
        ap_in = i_user[0] && !(over && ma == '0);
        bp_in = i_user[1] && !(over && ma != '0 && mb == '0);
    end

    always_comb begin
        sum     = r2_wa + r2_wb;
        n_ka    = '0;
        n_kb    = '0;
        n_div   = 16'd1;
        n_alpha = '0;
        if (r2_ap && r2_bp) begin
            if (sum != '0) begin
                n_ka    = r2_wa;
                n_kb    = r2_wb;
                n_div   = sum;
                n_alpha = sum;
            end
        end else if (r2_ap) begin
            if (!r2_ma_zero) begin
                n_ka    = 16'd1;
                n_alpha = r2_p;
            end
        end else if (r2_bp) begin
            if (!r2_mb_zero) begin
                n_kb    = 16'd1;
                n_alpha = r2_wb;
            end
        end
    end

    always_comb begin
        logic signed [32:0] pa, pb;
        logic signed [rcom_pkg::NUM_W-1:0] num;
        for (int c = 0; c < 3; c++) begin
            pa = $signed(r3_ca[c]) * $signed({1'b0, r3_ka});
            pb = $signed(r3_cb[c]) * $signed({1'b0, r3_kb});
            n_pa[c] = pa[rcom_pkg::NUM_W-1:0];
            n_pb[c] = pb[rcom_pkg::NUM_W-1:0];
        end
        n_job.div   = r4_div;
        n_job.alpha = r4_alpha;
        for (int c = 0; c < 3; c++) begin
            num = $signed(r4_pa[c]) + $signed(r4_pb[c]);
            n_job.neg[c] = num[rcom_pkg::NUM_W-1];
            n_job.mag[c] = num[rcom_pkg::NUM_W-1] ? 31'(-num) : num[rcom_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[3:0], i_valid};
        end
        if (adv) begin
            r1_over    <= (i_cfg.mode == rcom_pkg::MODE_OVER);
            r1_ma_zero <= (ma == '0);
            r1_mb_zero <= (mb == '0);
            r1_ap      <= ap_in;
            r1_bp      <= bp_in;
            r1_p       <= rcom_pkg::amul(a_al, ma);
            r1_wb      <= rcom_pkg::amul(b_al, mb);
            for (int c = 0; c < 3; c++) begin
                r1_ca[c] <= i_data[16*c +: 16];
                r1_cb[c] <= i_data[64 + 16*c +: 16];
            end
            r2_ma_zero <= r1_ma_zero;
            r2_mb_zero <= r1_mb_zero;
            r2_ap      <= r1_ap;
            r2_bp      <= r1_bp;
            r2_p       <= r1_p;
            r2_wb      <= r1_wb;
            r2_wa      <= r1_over ? rcom_pkg::amul(r1_p, rcom_pkg::ALPHA_ONE - r1_wb) : r1_p;
            r2_ca      <= r1_ca;
            r2_cb      <= r1_cb;
            r3_ka      <= n_ka;
            r3_kb      <= n_kb;
            r3_div     <= n_div;
            r3_alpha   <= n_alpha;
            r3_ca      <= r2_ca;
            r3_cb      <= r2_cb;
            r4_pa      <= n_pa;
            r4_pb      <= n_pb;
            r4_div     <= r3_div;
            r4_alpha   <= r3_alpha;
            r5_job     <= n_job;
        end
    end

endmodule

// ===== hdl/rcom_fifo.sv =====
// short word queue between front and back pipelines
// depends on rcom_pkg and assert_macros.svh
`include "assert_macros.svh"
module rcom_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcom_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output rcom_pkg::t_job o_job
);

    rcom_pkg::t_job r_mem [rcom_pkg::FIFO_DEPTH];
    logic [rcom_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [rcom_pkg::FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (rcom_pkg::FIFO_AW+1)'(rcom_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (rcom_pkg::FIFO_AW+1)'(i_push)
                               - (rcom_pkg::FIFO_AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `RCOM_ASSERT(a_count_max, r_count <= (rcom_pkg::FIFO_AW+1)'(rcom_pkg::FIFO_DEPTH), "queue overfilled")
    `RCOM_ASSERT(a_push_lands, i_push && !i_pop |=> r_count == $past(r_count) + 1'b1, "push lost")

endmodule

// ===== hdl/rcom_back.sv =====
// back pipeline: one quotient bit per stage for three channels, sign fix, output register
// depends on rcom_pkg and assert_macros.svh
`include "assert_macros.svh"
module rcom_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  rcom_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_data
);

    localparam int S = rcom_pkg::DIV_STEPS;

    logic [S:0]                    r_v;
    logic [2:0][15:0]              r_rem [S+1];
    logic [2:0][15:0]              r_low [S+1];
    logic [15:0]                   r_div [S+1];
    logic [15:0]                   r_alpha [S+1];
    logic [2:0]                    r_neg [S+1];
    logic [2:0][15:0]              n_rem [S+1];
    logic [2:0][15:0]              n_low [S+1];
    logic                          r_out_v;
    logic [63:0]                   r_out;
    logic [63:0]                   n_out;
    logic                          adv;

    assign adv     = !r_out_v || i_ready;
    assign o_pop   = adv && !i_empty;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_comb begin
        logic [16:0] t, d;
        logic        ge;
        for (int c = 0; c < 3; c++) begin
            n_rem[0][c] = {1'b0, i_job.mag[c][30:16]};
            n_low[0][c] = i_job.mag[c][15:0];
        end
        for (int s = 0; s < S; s++) begin
            for (int c = 0; c < 3; c++) begin
                t  = {r_rem[s][c], r_low[s][c][15]};
                d  = t - {1'b0, r_div[s]};
                ge = (t >= {1'b0, r_div[s]});
                n_rem[s+1][c] = ge ? d[15:0] : t[15:0];
                n_low[s+1][c] = {r_low[s][c][14:0], ge};
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_out[16*c +: 16] = r_neg[S][c] ? 16'(-r_low[S][c]) : r_low[S][c];
        end
        n_out[63:48] = r_alpha[S];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_v     <= {r_v[S-1:0], o_pop};
            r_out_v <= r_v[S];
        end
        if (adv) begin
            r_rem[0]   <= n_rem[0];
            r_low[0]   <= n_low[0];
            r_div[0]   <= i_job.div;
            r_alpha[0] <= i_job.alpha;
            r_neg[0]   <= i_job.neg;
            for (int s = 1; s <= S; s++) begin
                r_rem[s]   <= n_rem[s];
                r_low[s]   <= n_low[s];
                r_div[s]   <= r_div[s-1];
                r_alpha[s] <= r_alpha[s-1];
                r_neg[s]   <= r_neg[s-1];
            end
            r_out <= n_out;
        end
    end

    `RCOM_ASSERT(a_pop_fills, o_pop |=> r_v[0], "popped word not in first stage")
    `RCOM_ASSERT(a_div_nonzero, r_v[0] |-> r_div[0] != 16'd0, "zero divisor in divider")
    `RCOM_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !r_out_v && r_v == '0, "valid after reset")

endmodule

// ===== hdl/rgba_crossfade_and_over_mixer.sv =====
// Mixes one aligned A/B pixel pair of straight-alpha RGBA per word, by cross
// dissolve or B over A. One word is taken every clock when the output side
// keeps up. From input handshake to output valid, a word passes through
// five front stages (clamp and weight products, over-mode weight, classification,
// color-weight products, numerator sum), the 4-word queue, and
// a 16-stage restoring divider producing one quotient bit per stage per color,
// followed by the output register; the divider stalls while its word is not taken.
// Configuration writes take effect for words accepted afterwards.
// depends on rcom_pkg, rcom_front, rcom_fifo, rcom_back
module rgba_crossfade_and_over_mixer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha
    input  logic [127:0] s_axis_tdata,
    // a_inside, b_inside
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [63:0]  m_axis_tdata
);

    rcom_pkg::t_cfg r_cfg;
    rcom_pkg::t_job front_job, fifo_job;
    logic           push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= rcom_pkg::MODE_CROSS;
            r_cfg.mix_a <= rcom_pkg::ALPHA_ONE;
            r_cfg.mix_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcom_pkg::CFG_MODE:  r_cfg.mode  <= i_cfg_data[0];
                rcom_pkg::CFG_MIX_A: r_cfg.mix_a <= i_cfg_data;
                rcom_pkg::CFG_MIX_B: r_cfg.mix_b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rcom_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    rcom_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (fifo_job)
    );

    rcom_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (fifo_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of rgba_crossfade_and_over_mixer: directed rows, a configuration sweep, then random pixels
// every accepted pixel pair is predicted locally and compared with the mixed word
// depends on rcom_pkg and the mixer rtl
`timescale 1ns / 1ps
module tb;

    localparam int LIMIT     = 400000;
    localparam int N_RAND    = 1650;
    localparam int LATENCY   = 23;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
    } t_pix;

    typedef struct {
        t_pix pa;
        t_pix pb;
        logic [1:0] present;
        logic has_exp;
        t_pix exp_pix;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;

    logic        cur_mode;
    logic [15:0] cur_mix_a;
    logic [15:0] cur_mix_b;
    t_pix        mixed_q[$];
    int          fails;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    rgba_crossfade_and_over_mixer dut (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [15:0] clamp_one(input logic [15:0] v);
        return (v > rcom_pkg::ALPHA_ONE) ? rcom_pkg::ALPHA_ONE : v;
    endfunction

    function automatic logic [15:0] wmul(input logic [15:0] x, input logic [15:0] y);
        logic [31:0] p;
        p = x * y;
        return p[30:15];
    endfunction

    function automatic t_pix mix_pixel(input t_pix pa, input t_pix pb, input logic [1:0] ins);
        logic [15:0] mb, ma, aa, ba, wa, wb, sum;
        logic        ap, bp, over;
        longint      num, q;
        logic [15:0] ca[3], cb[3], res[3];
        t_pix        o;
        o = '0;
        over = cur_mode == rcom_pkg::MODE_OVER;
        mb = clamp_one(cur_mix_b);
        ma = over ? clamp_one(cur_mix_a) : rcom_pkg::ALPHA_ONE - mb;
        aa = clamp_one(pa.a);
        ba = clamp_one(pb.a);
        ap = ins[0];
        bp = ins[1];
        ca = '{pa.r, pa.g, pa.b};
        cb = '{pb.r, pb.g, pb.b};
        if (over) begin
            if (ma == 0) ap = 1'b0;
            else if (mb == 0) bp = 1'b0;
        end
        if (ap && bp) begin
            wb = wmul(ba, mb);
            wa = over ? wmul(wmul(aa, ma), rcom_pkg::ALPHA_ONE - wb) : wmul(aa, ma);
            sum = wa + wb;
            if (sum != 0) begin
                for (int k = 0; k < 3; k++) begin
                    num = longint'($signed(ca[k])) * longint'(wa)
                        + longint'($signed(cb[k])) * longint'(wb);
                    q = num / longint'(sum);
                    res[k] = q[15:0];
                end
                o = '{res[0], res[1], res[2], sum};
            end
        end else if (ap) begin
            if (ma != 0) o = '{pa.r, pa.g, pa.b, wmul(aa, ma)};
        end else if (bp) begin
            if (mb != 0) o = '{pb.r, pb.g, pb.b, wmul(ba, mb)};
        end
        return o;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rcom_pkg::CFG_MODE:  cur_mode  = val[0];
            rcom_pkg::CFG_MIX_A: cur_mix_a = val;
            rcom_pkg::CFG_MIX_B: cur_mix_b = val;
            default: begin
            end
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (mixed_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic wait_empty();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (mixed_q.size() != 0);
    endtask

    task automatic send_pixel(input t_pix pa, input t_pix pb, input logic [1:0] ins,
                              input logic has_exp, input t_pix exp_pix);
        t_pix pred;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pred = mix_pixel(pa, pb, ins);
        if (has_exp && pred != exp_pix) begin
            $error("table row disagrees with predictor: %h vs %h", exp_pix, pred);
            fails++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pb.a, pb.b, pb.g, pb.r, pa.a, pa.b, pa.g, pa.r};
        s_axis_tuser  <= ins;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mixed_q.push_back(has_exp ? exp_pix : pred);
    endtask

    function automatic logic [15:0] rand_alpha();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return rcom_pkg::ALPHA_ONE;
            2: return 16'hffff;
            3: return 16'(rcom_pkg::ALPHA_ONE + $urandom_range(32767));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [15:0] rand_mix();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return rcom_pkg::ALPHA_ONE;
            2: return 16'(rcom_pkg::ALPHA_ONE + $urandom_range(32767));
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic t_pix rand_pix();
        t_pix p;
        p.r = 16'($urandom);
        p.g = 16'($urandom);
        p.b = 16'($urandom);
        p.a = rand_alpha();
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            t_pix got, want;
            got = m_axis_tdata;
            if (mixed_q.size() == 0) begin
                $error("mixed word with nothing expected: %h", m_axis_tdata);
                fails++;
            end else begin
                want = mixed_q.pop_front();
                got  = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                        m_axis_tdata[63:48]};
                if (got.r != want.r) begin
                    $error("out_red expected %h got %h", want.r, got.r); fails++;
                end
                if (got.g != want.g) begin
                    $error("out_green expected %h got %h", want.g, got.g); fails++;
                end
                if (got.b != want.b) begin
                    $error("out_blue expected %h got %h", want.b, got.b); fails++;
                end
                if (got.a != want.a) begin
                    $error("out_alpha expected %h got %h", want.a, got.a); fails++;
                end
            end
        end
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_pix z, pmax, pmin, pw;
        int phase;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b1;
        fails = 0; cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
        cur_mode = rcom_pkg::MODE_CROSS; cur_mix_a = rcom_pkg::ALPHA_ONE; cur_mix_b = 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z    = '0;
        pmax = '{16'h7fff, 16'h7fff, 16'h7fff, rcom_pkg::ALPHA_ONE};
        pmin = '{16'h8000, 16'h8000, 16'h8000, rcom_pkg::ALPHA_ONE};
        pw   = '{16'h1234, 16'hedcb, 16'h0800, 16'hffff};
        // reset config: cross with mix_b zero passes A fully
        rows.push_back('{pmax, pmin, 2'b11, 1'b1, pmax});
        rows.push_back('{pmin, pmax, 2'b01, 1'b1, pmin});
        rows.push_back('{pmax, pmin, 2'b10, 1'b1, z});
        rows.push_back('{pmax, pmin, 2'b00, 1'b1, z});
        rows.push_back('{pw, pmax, 2'b01, 1'b1,
                         '{16'h1234, 16'hedcb, 16'h0800, rcom_pkg::ALPHA_ONE}});
        rows.push_back('{z, z, 2'b11, 1'b1, z});
        rows.push_back('{pw, pmin, 2'b11, 1'b0, z});
        foreach (rows[i])
            send_pixel(rows[i].pa, rows[i].pb, rows[i].present, rows[i].has_exp,
                       rows[i].exp_pix);
        drain();
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin write_reg(rcom_pkg::CFG_MIX_B, 16'hffff); end
                1: begin write_reg(rcom_pkg::CFG_MIX_B, 16'h4000); end
                2: begin
                    write_reg(rcom_pkg::CFG_MODE, 16'(rcom_pkg::MODE_OVER));
                    write_reg(rcom_pkg::CFG_MIX_A, 16'h0000);
                end
                3: begin
                    write_reg(rcom_pkg::CFG_MIX_A, 16'hffff);
                    write_reg(rcom_pkg::CFG_MIX_B, 16'h0000);
                end
                4: begin
                    write_reg(rcom_pkg::CFG_MIX_A, 16'h6000);
                    write_reg(rcom_pkg::CFG_MIX_B, rcom_pkg::ALPHA_ONE);
                end
                default: begin
                    write_reg(rcom_pkg::CFG_MIX_A, 16'h2000);
                    write_reg(rcom_pkg::CFG_MIX_B, 16'h3000);
                end
            endcase
            send_pixel(pmax, pmin, 2'b11, 1'b0, z);
            send_pixel(pw, pmax, 2'b11, 1'b0, z);
            send_pixel(pw, pmin, 2'b01, 1'b0, z);
            send_pixel(pmin, pw, 2'b10, 1'b0, z);
            drain();
        end

        for (int n = 0; n < N_RAND; n++) begin
            phase = (n * 4) / N_RAND;
            send_idle_pct  = (phase == 1) ? 47 : (phase == 3) ? 20 : 0;
            recv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 20 : 0;
            if (n % 150 == 0) begin
                drain();
                write_reg(rcom_pkg::CFG_MODE, 16'($urandom_range(1)));
                write_reg(rcom_pkg::CFG_MIX_A, rand_mix());
                write_reg(rcom_pkg::CFG_MIX_B, rand_mix());
            end
            if (n % 97 == 50) begin
                wait_empty();
            end
            send_pixel(rand_pix(), rand_pix(), 2'($urandom), 1'b0, z);
        end
        drain();
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
